[sv/epp_pkg.sv]
// ----------------------------------------------------------------------------
// ESC pulse profile player package
// Shared word types, command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package epp_pkg;

  // Command codes carried in the func field of an input word.
  typedef enum logic [2:0] {
    FUNC_TICK = 3'd0,
    FUNC_LOAD = 3'd1,
    FUNC_PLAY = 3'd2,
    FUNC_JOG  = 3'd3,
    FUNC_STOP = 3'd4
  } epp_func_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_MIN_PULSE   = 3'd0,
    CFG_MAX_PULSE   = 3'd1,
    CFG_JOG_FWD     = 3'd2,
    CFG_JOG_BWD     = 3'd3,
    CFG_JOG_TIMEOUT = 3'd4
  } epp_cfg_idx_t;

  // Top-level sequencing: the store is swept to zero after reset.
  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } epp_state_t;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 16;

  localparam logic [15:0] RST_MIN_PULSE   = 16'd1000;
  localparam logic [15:0] RST_MAX_PULSE   = 16'd2000;
  localparam logic [15:0] RST_JOG_FWD     = 16'd1100;
  localparam logic [15:0] RST_JOG_BWD     = 16'd900;
  localparam logic [15:0] RST_JOG_TIMEOUT = 16'd1000;

  localparam logic [15:0] JOG_SAT = 16'hFFFF;

  // ceil(2^32 / 255). For any product below 2^24, (x * MAP_RECIP) >> 32
  // equals x / 255 exactly, since the rounding error stays under 1/255.
  localparam logic [24:0] MAP_RECIP = 25'd16843010;

  // Input word.
  typedef struct packed {
    logic [2:0]  func;
    logic [11:0] sample_index;
    logic [7:0]  sample_byte;
    logic        jog_forward;
  } epp_in_t;

  // Result word.
  typedef struct packed {
    logic [15:0] pulse_width;
    logic        pulse_written;
    logic        playback_done;
  } epp_out_t;

  // Per-stage result descriptor travelling down the map pipeline.
  typedef struct packed {
    logic        use_map;
    logic [15:0] pw;
    logic        written;
    logic        done;
  } epp_stage_t;

endpackage

[sv/esc_pulse_profile_player.sv]
// ----------------------------------------------------------------------------
// ESC pulse profile player
// Plays a byte profile from an on-chip store as ESC pulse widths, with a
// timed jog and an idle minimum pulse.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid / in_stall) carry a command: a one millisecond tick,
//   a profile sample load, start playback, start jog or stop jog. Only a tick
//   produces a result word on the out_ channel; other commands produce none.
//   Configuration registers are written through cfg_we / cfg_addr / cfg_wdata
//   by the user only while the block is idle; the block itself does not
//   enforce this. One input word is accepted per cycle while in_stall is low.
//   A tick's result reaches the output register through a chain of registers:
//   the store read is registered at the edge that accepts the tick, then the
//   byte times span multiply, the reciprocal multiply for the divide by 255
//   and the final add take one register each.
//   When the receiver stalls a full output register, the output word holds
//   and the pipeline freezes; after the sweep, input is stalled only while
//   the output register is full and not taken. After reset the profile store
//   is swept to zero, one entry per cycle, and in_stall is held high
//   throughout; configuration writes are accepted during the sweep.
// ----------------------------------------------------------------------------
module esc_pulse_profile_player
  import epp_pkg::*;
#(
  parameter int PROFILE_LEN = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  epp_in_t           in_word,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output epp_out_t          out_word,
  // configuration port
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int AW = (PROFILE_LEN > 1) ? $clog2(PROFILE_LEN) : 1;
  localparam int PW = $clog2(PROFILE_LEN + 1);
  localparam logic [PW-1:0] PLAY_END = PW'(PROFILE_LEN);
  localparam logic [AW-1:0] LAST_ADDR = AW'(PROFILE_LEN - 1);

  // Configuration registers.
  logic [15:0] min_pulse_r, max_pulse_r, jog_fwd_r, jog_bwd_r, jog_timeout_r;

  // Control state.
  epp_state_t  state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic          playing_r, playing_nxt;
  logic          jogging_r, jogging_nxt;
  logic          jog_dir_r, jog_dir_nxt;
  logic [PW-1:0] play_elapsed_r, play_elapsed_nxt;
  logic [15:0]   jog_elapsed_r, jog_elapsed_nxt;

  // Pipeline.
  logic          adv;
  logic          in_acc;
  logic          s0_vld;
  epp_stage_t    s0;
  logic          s1_vld_r, s2_vld_r, s3_vld_r;
  epp_stage_t    s1_r, s2_r, s3_r;
  logic [23:0]   prod_r, prod_nxt;
  logic [15:0]   quot_r, quot_nxt;
  logic [48:0]   recip_prod;
  logic          out_valid_r;
  epp_out_t      out_word_r, out_word_nxt;

  // Profile store.
  logic [7:0]    mem [PROFILE_LEN];
  logic [7:0]    rdata_r;
  logic          mem_re, mem_we, load_we, load_in_range;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  // Mapping span.
  logic          map_neg;
  logic [15:0]   map_span;

  // Configuration writes; unlisted indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pulse_r   <= RST_MIN_PULSE;
      max_pulse_r   <= RST_MAX_PULSE;
      jog_fwd_r     <= RST_JOG_FWD;
      jog_bwd_r     <= RST_JOG_BWD;
      jog_timeout_r <= RST_JOG_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MIN_PULSE:   min_pulse_r   <= cfg_wdata;
        CFG_MAX_PULSE:   max_pulse_r   <= cfg_wdata;
        CFG_JOG_FWD:     jog_fwd_r     <= cfg_wdata;
        CFG_JOG_BWD:     jog_bwd_r     <= cfg_wdata;
        CFG_JOG_TIMEOUT: jog_timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is free or being taken.
  assign adv    = !out_valid_r || !out_stall;
  assign in_acc = in_valid && !in_stall;

  // Next state of the clearing sweep.
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: ;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Outputs of the sweep: input stall and the store write port.
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = 8'd0;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_RUN: begin
        in_stall  = !adv;
        mem_we    = load_we;
        mem_waddr = AW'(in_word.sample_index);
        mem_wdata = in_word.sample_byte;
      end
      default: ;
    endcase
  end

  assign load_in_range = (32'(in_word.sample_index) < 32'(PROFILE_LEN));

  // Command decode and the tick decision; the playback and jog state updates here.
  always_comb begin
    playing_nxt      = playing_r;
    jogging_nxt      = jogging_r;
    jog_dir_nxt      = jog_dir_r;
    play_elapsed_nxt = play_elapsed_r;
    jog_elapsed_nxt  = jog_elapsed_r;
    load_we          = 1'b0;
    mem_re           = 1'b0;
    s0_vld           = 1'b0;
    s0               = '0;
    if (in_acc) begin
      case (in_word.func)
        FUNC_LOAD: begin
          load_we = load_in_range;
        end
        FUNC_PLAY: begin
          playing_nxt      = 1'b1;
          play_elapsed_nxt = '0;
        end
        FUNC_JOG: begin
          jogging_nxt     = 1'b1;
          jog_dir_nxt     = in_word.jog_forward;
          jog_elapsed_nxt = '0;
        end
        FUNC_STOP: begin
          jogging_nxt = 1'b0;
        end
        FUNC_TICK: begin
          s0_vld = 1'b1;
          if (playing_r) begin
            if (play_elapsed_r == PLAY_END) begin
              playing_nxt = 1'b0;
              s0.done     = 1'b1;
            end else begin
              s0.use_map       = 1'b1;
              s0.written       = 1'b1;
              mem_re           = 1'b1;
              play_elapsed_nxt = play_elapsed_r + PW'(1);
            end
            // Jog time keeps running underneath playback.
            if (jogging_r && jog_elapsed_r != JOG_SAT) begin
              jog_elapsed_nxt = jog_elapsed_r + 16'd1;
            end
          end else if (jogging_r) begin
            s0.written = 1'b1;
            if (jog_elapsed_r > jog_timeout_r) begin
              s0.pw       = min_pulse_r;
              jogging_nxt = 1'b0;
            end else begin
              s0.pw = jog_dir_r ? jog_fwd_r : jog_bwd_r;
              if (jog_elapsed_r != JOG_SAT) begin
                jog_elapsed_nxt = jog_elapsed_r + 16'd1;
              end
            end
          end else begin
            s0.pw      = min_pulse_r;
            s0.written = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_addr_r     <= '0;
      playing_r      <= 1'b0;
      jogging_r      <= 1'b0;
      jog_dir_r      <= 1'b0;
      play_elapsed_r <= '0;
      jog_elapsed_r  <= '0;
    end else begin
      state_r        <= state_nxt;
      clr_addr_r     <= clr_addr_nxt;
      playing_r      <= playing_nxt;
      jogging_r      <= jogging_nxt;
      jog_dir_r      <= jog_dir_nxt;
      play_elapsed_r <= play_elapsed_nxt;
      jog_elapsed_r  <= jog_elapsed_nxt;
    end
  end

  // Profile store: one write port, one registered read port. Reads happen
  // only on accepted ticks, so the read data holds while the pipeline stalls.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[play_elapsed_r[AW-1:0]];
    end
  end

  // Span of the map and its direction.
  assign map_neg  = (max_pulse_r < min_pulse_r);
  assign map_span = map_neg ? (min_pulse_r - max_pulse_r) : (max_pulse_r - min_pulse_r);

  // Byte times span, then division by 255 through a reciprocal multiply.
  assign prod_nxt   = {16'd0, rdata_r} * {8'd0, map_span};
  assign recip_prod = {25'd0, prod_r} * {24'd0, MAP_RECIP};
  assign quot_nxt   = recip_prod[47:32];

  // Final add of the mapped offset, or the value decided at the tick.
  always_comb begin
    out_word_nxt.pulse_written = s3_r.written;
    out_word_nxt.playback_done = s3_r.done;
    if (s3_r.use_map) begin
      out_word_nxt.pulse_width = map_neg ? (min_pulse_r - quot_r) : (min_pulse_r + quot_r);
    end else begin
      out_word_nxt.pulse_width = s3_r.pw;
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r    <= s0_vld;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      out_valid_r <= s3_vld_r;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r       <= s0;
      s2_r       <= s1_r;
      prod_r     <= prod_nxt;
      s3_r       <= s2_r;
      quot_r     <= quot_nxt;
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  // No input word is taken while the store is being cleared.
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> in_stall)
    else $error("input accepted during store clearing");

  // A playback end word never carries a pulse.
  a_done_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.playback_done) |->
      (!out_word_r.pulse_written && out_word_r.pulse_width == 16'd0))
    else $error("playback end word carries a pulse");

  // The playback position never runs past the profile end.
  a_play_bound: assert property (@(posedge clk) disable iff (!rst_n)
    play_elapsed_r <= PLAY_END)
    else $error("playback position beyond profile length");

  // A tick accepted while the pipeline is moving shows up in stage one.
  a_tick_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_word.func == FUNC_TICK) |=> s1_vld_r)
    else $error("accepted tick lost at pipeline entry");
`endif

endmodule
